/* rtl/core/hktlc_pkg.sv */
// shared types, constants and the hash fold for the hashed key two-level cache
// no dependencies
package hktlc_pkg;

	localparam int unsigned SLOTS_DEF = 16;

	localparam logic [63:0] HASH_INIT   = 64'hcbf29ce484222325;
	localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;

	localparam logic [1:0] STATUS_NEAR_HIT = 2'd0;
	localparam logic [1:0] STATUS_FAR_HIT  = 2'd1;
	localparam logic [1:0] STATUS_MISS     = 2'd2;

	typedef struct packed {
		logic fold;
		logic near_hit;
		logic scan_clr;
		logic rd;
		logic scan_inc;
		logic far_hit;
		logic miss;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic near_match;
		logic tag_match;
		logic scan_last;
		logic out_busy;
	} sts_t;

	function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] w);
		logic [63:0] sum;
		sum = w + HASH_GOLDEN + {h[57:0], 6'b0} + {2'b0, h[63:2]};
		return h ^ sum;
	endfunction

endpackage

/* rtl/core/hktlc_ctrl.sv */
// controller state machine for the hashed key two-level cache
// depends on hktlc_pkg; drives commands into hktlc_dpath
module hktlc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_word,
	output logic               in_ready,
	input  hktlc_pkg::sts_t    sts,
	output hktlc_pkg::cmd_t    cmd
);
	import hktlc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NEAR = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.fold = in_valid;
				if (in_valid && last_word) begin
					state_d = ST_NEAR;
				end
			end
			ST_NEAR: begin
				if (sts.near_match) begin
					cmd.near_hit = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.tag_match) begin
					cmd.far_hit = 1'b1;
					state_d     = ST_DONE;
				end else if (sts.scan_last) begin
					cmd.miss = 1'b1;
					state_d  = ST_DONE;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/hktlc_dpath.sv */
// datapath: running hash, near level, slot tag memory, valid bits, result register
// depends on hktlc_pkg; commanded by hktlc_ctrl
module hktlc_dpath #(
	parameter int unsigned SLOTS = hktlc_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        key_word,
	input  logic               last_word,
	input  hktlc_pkg::cmd_t    cmd,
	output hktlc_pkg::sts_t    sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         lookup_status,
	output logic [3:0]         slot_index,
	output logic [63:0]        fingerprint_out
);
	import hktlc_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

	logic [63:0]      hash_q;
	logic [63:0]      fp_q;
	logic [63:0]      fold_d;
	logic             near_valid_q;
	logic [63:0]      near_tag_q;
	logic [IDX_W-1:0] near_slot_q;
	logic [63:0]      tag_mem [SLOTS];
	logic [SLOTS-1:0] slot_valid_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] scan_q;
	logic [63:0]      rd_tag_q;
	logic             rd_vld_q;
	logic [1:0]       res_status_q;
	logic [IDX_W-1:0] res_slot_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [3:0]       out_slot_q;
	logic [63:0]      out_fp_q;

	assign fold_d = fold_word(hash_q, key_word);

	assign sts.near_match = near_valid_q && (near_tag_q == fp_q);
	assign sts.tag_match  = rd_vld_q && (rd_tag_q == fp_q);
	assign sts.scan_last  = (scan_q == IDX_LAST);
	assign sts.out_busy   = out_valid_q && !out_ready;

	// hash and fingerprint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_INIT;
		end else if (cmd.fold) begin
			hash_q <= last_word ? HASH_INIT : fold_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fold && last_word) begin
			fp_q <= fold_d;
		end
	end

	// tag memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && res_status_q == STATUS_MISS) begin
			tag_mem[res_slot_q] <= fp_q;
		end
		if (cmd.rd) begin
			rd_tag_q <= tag_mem[scan_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			fill_q       <= '0;
			rd_vld_q     <= 1'b0;
			scan_q       <= '0;
		end else begin
			if (cmd.rd) begin
				rd_vld_q <= slot_valid_q[scan_q];
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.commit && res_status_q == STATUS_MISS) begin
				slot_valid_q[res_slot_q] <= 1'b1;
				fill_q <= (fill_q == IDX_LAST) ? '0 : fill_q + 1'b1;
			end
		end
	end

	// lookup result
	always_ff @(posedge clk) begin
		if (cmd.near_hit) begin
			res_status_q <= STATUS_NEAR_HIT;
			res_slot_q   <= near_slot_q;
		end else if (cmd.far_hit) begin
			res_status_q <= STATUS_FAR_HIT;
			res_slot_q   <= scan_q;
		end else if (cmd.miss) begin
			res_status_q <= STATUS_MISS;
			res_slot_q   <= fill_q;
		end
	end

	// near level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_valid_q <= 1'b0;
			near_tag_q   <= '0;
			near_slot_q  <= '0;
		end else if (cmd.commit && res_status_q != STATUS_NEAR_HIT) begin
			near_valid_q <= 1'b1;
			near_tag_q   <= fp_q;
			near_slot_q  <= res_slot_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status_q;
			out_slot_q   <= 4'(res_slot_q);
			out_fp_q     <= fp_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign lookup_status   = out_status_q;
	assign slot_index      = out_slot_q;
	assign fingerprint_out = out_fp_q;

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("result committed over an untaken transfer");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_miss_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res_status_q == STATUS_MISS) |=> slot_valid_q[$past(res_slot_q)])
		else $error("allocated slot not marked valid");

	a_near_filled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> near_valid_q)
		else $error("near level empty after a lookup");
`endif

endmodule

/* rtl/core/hashed_key_two_level_cache.sv */
// top level of the hashed key two-level cache
// depends on hktlc_pkg, hktlc_ctrl and hktlc_dpath
//
// key words arrive on the input channel (in_valid/in_ready, key_word, last_word).
// a word without last_word folds into the running hash; words stream at one per
// cycle between lookups. a word with last_word completes the fingerprint
// and starts a lookup; in_ready stays low until the lookup is finished.
// one result per key leaves on the output channel (out_valid/out_ready,
// lookup_status, slot_index, fingerprint_out):
//   near level hit: the near level's tag, checked first, matches the fingerprint
//   far level hit in slot i: slot tags are read in turn through the tag memory's
//     registered read port, and each is compared before the next is read
//   miss: the slot at the round-robin pointer is claimed
// the result sits in an output register, so key words are taken again while it
// waits; a stalled receiver only holds the next lookup before its result is
// written. reset clears all valid bits, the fill pointer and the hash at once.
module hashed_key_two_level_cache #(
	parameter int unsigned SLOTS = hktlc_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] key_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  lookup_status,
	output logic [3:0]  slot_index,
	output logic [63:0] fingerprint_out
);
	import hktlc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hktlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_word (last_word),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hktlc_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.key_word        (key_word),
		.last_word       (last_word),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.lookup_status   (lookup_status),
		.slot_index      (slot_index),
		.fingerprint_out (fingerprint_out)
	);

endmodule

/* test/hashed_key_two_level_cache_checker.sv */
// transfer monitor, fingerprint predictor and result comparator for hashed_key_two_level_cache
// depends on hktlc_pkg for the hash constants, the slot count and status codes
module hashed_key_two_level_cache_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] key_word,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  lookup_status,
	input  logic [3:0]  slot_index,
	input  logic [63:0] fingerprint_out,
	output int          pending,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import hktlc_pkg::*;

	localparam int N_SLOTS = SLOTS_DEF;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [63:0] fp;
	} lookup_result_t;

	lookup_result_t expected_lookups[$];

	logic [63:0] fp_accum;
	logic        l1_valid;
	logic [63:0] l1_tag;
	logic [3:0]  l1_slot;
	logic [63:0] l2_tag [N_SLOTS];
	logic        l2_valid [N_SLOTS];
	int          next_fill;

	function automatic logic [63:0] mix_word(input logic [63:0] h, input logic [63:0] w);
		logic [63:0] t;
		t = (h << 6) + (h >> 2);
		t = t + w + HASH_GOLDEN;
		return h ^ t;
	endfunction

	task automatic clear_model();
		fp_accum = HASH_INIT;
		l1_valid = 1'b0;
		l1_tag = '0;
		l1_slot = '0;
		for (int i = 0; i < N_SLOTS; i++) begin
			l2_tag[i] = '0;
			l2_valid[i] = 1'b0;
		end
		next_fill = 0;
	endtask

	task automatic predict_lookup(input logic [63:0] w, input logic l);
		lookup_result_t res;
		logic [63:0] fp;
		int hit_slot;
		fp = mix_word(fp_accum, w);
		fp_accum = fp;
		if (l) begin
			fp_accum = HASH_INIT;
			res.fp = fp;
			if (l1_valid && l1_tag == fp) begin
				res.status = STATUS_NEAR_HIT;
				res.slot = l1_slot;
			end else begin
				hit_slot = -1;
				for (int i = 0; i < N_SLOTS; i++) begin
					if (hit_slot < 0 && l2_valid[i] && l2_tag[i] == fp)
						hit_slot = i;
				end
				if (hit_slot >= 0) begin
					res.status = STATUS_FAR_HIT;
				end else begin
					res.status = STATUS_MISS;
					hit_slot = next_fill;
					l2_tag[hit_slot] = fp;
					l2_valid[hit_slot] = 1'b1;
					next_fill = (hit_slot + 1) % N_SLOTS;
				end
				res.slot = hit_slot[3:0];
				l1_valid = 1'b1;
				l1_tag = fp;
				l1_slot = hit_slot[3:0];
			end
			expected_lookups.push_back(res);
		end
	endtask

	task automatic compare_result();
		lookup_result_t exp_res;
		if (expected_lookups.size() == 0) begin
			$display("%0t: unexpected result status %0d slot %0d fp %h", $time,
				lookup_status, slot_index, fingerprint_out);
			fail_count++;
		end else begin
			exp_res = expected_lookups.pop_front();
			if (lookup_status !== exp_res.status) begin
				$display("%0t: lookup_status expected %0d actual %0d", $time,
					exp_res.status, lookup_status);
				fail_count++;
			end
			if (slot_index !== exp_res.slot) begin
				$display("%0t: slot_index expected %0d actual %0d", $time,
					exp_res.slot, slot_index);
				fail_count++;
			end
			if (fingerprint_out !== exp_res.fp) begin
				$display("%0t: fingerprint_out expected %h actual %h", $time,
					exp_res.fp, fingerprint_out);
				fail_count++;
			end
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_lookups.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready)
				compare_result();
			if (in_valid && in_ready)
				predict_lookup(key_word, last_word);
			pending = expected_lookups.size();
		end
	end

endmodule

/* test/hashed_key_two_level_cache_test.sv */
// stimulus and verdict for hashed_key_two_level_cache: directed keys, then pooled random keys and noise keys
// depends on hktlc_pkg, the block and hashed_key_two_level_cache_checker
module hashed_key_two_level_cache_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hktlc_pkg::*;

	localparam int KEYS        = 24;
	localparam int MAX_LEN     = 4;
	localparam int WORD_TARGET = 512;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 2 * SLOTS_DEF + 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] key_word;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  lookup_status;
	logic [3:0]  slot_index;
	logic [63:0] fingerprint_out;
	int          pending;
	int          fail_count;

	bit          calm;
	bit          hold_req;
	int          words_sent;
	logic [63:0] key_pool [KEYS][MAX_LEN];
	int          key_len [KEYS];

	hashed_key_two_level_cache u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_word        (key_word),
		.last_word       (last_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.lookup_status   (lookup_status),
		.slot_index      (slot_index),
		.fingerprint_out (fingerprint_out)
	);

	hashed_key_two_level_cache_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_word        (key_word),
		.last_word       (last_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.lookup_status   (lookup_status),
		.slot_index      (slot_index),
		.fingerprint_out (fingerprint_out),
		.pending         (pending),
		.fail_count      (fail_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [63:0] rand_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic make_key(input int idx);
		key_len[idx] = $urandom_range(1, MAX_LEN);
		for (int j = 0; j < MAX_LEN; j++)
			key_pool[idx][j] = rand_word();
	endtask

	task automatic push_word(input logic [63:0] w, input logic l);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_word <= w;
		last_word <= l;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_key(input int idx);
		for (int j = 0; j < key_len[idx]; j++)
			push_word(key_pool[idx][j], j == key_len[idx] - 1);
	endtask

	// receiver side: random stalls, one long hold-off, none once calm
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin
		int last_idx;
		int pick;
		int idx;
		int len;
		bit held;
		bit drained;
		in_valid = 1'b0;
		key_word = '0;
		last_word = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, near hit, far hit, multi-word keys
		push_word('0, 1'b1);
		push_word('0, 1'b1);
		push_word('1, 1'b0);
		push_word('1, 1'b1);
		push_word('0, 1'b1);
		push_word('1, 1'b1);
		push_word(64'h5555555555555555, 1'b0);
		push_word(64'haaaaaaaaaaaaaaaa, 1'b0);
		push_word('0, 1'b1);
		push_word('1, 1'b1);
		push_word('1, 1'b1);
		push_word(64'h8000000000000001, 1'b1);

		for (int i = 0; i < KEYS; i++)
			make_key(i);
		last_idx = 0;
		held = 1'b0;
		drained = 1'b0;
		while (words_sent < WORD_TARGET) begin
			if (!held && words_sent >= 150) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!drained && words_sent >= 300) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
				repeat (TAIL_CYCLES) @(posedge clk);
			end
			if (words_sent >= 420)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				send_key(last_idx);
			end else if (pick < 85) begin
				idx = $urandom_range(0, KEYS - 1);
				if ($urandom_range(0, 19) == 0)
					make_key(idx);
				send_key(idx);
				last_idx = idx;
			end else begin
				// noise: throwaway key of random words
				len = $urandom_range(1, MAX_LEN);
				for (int j = 0; j < len; j++)
					push_word({$urandom, $urandom}, j == len - 1);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("hashed_key_two_level_cache regression: pass");
		else
			$display("hashed_key_two_level_cache regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("hashed_key_two_level_cache regression: fail");
		$finish;
	end

endmodule

/* files.f */
rtl/core/hktlc_pkg.sv
rtl/core/hktlc_ctrl.sv
rtl/core/hktlc_dpath.sv
rtl/core/hashed_key_two_level_cache.sv
test/hashed_key_two_level_cache_checker.sv
test/hashed_key_two_level_cache_test.sv
